@@ rtl/binary_max_heap_queue_macros.svh @@
// assertion macros for the binary max-heap priority queue
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

// property checked on every clock edge outside reset
`define BMHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after its trigger
`define BMHQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bmhq_pkg.sv @@
// shared types and codes of the binary max-heap priority queue
// no dependencies
package bmhq_pkg;

  // opcode field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // capacity register
  localparam int unsigned  CAP_W     = 7;
  localparam logic [6:0]   CAP_RESET = 7'd64;
  localparam int unsigned  TOTAL_W   = 7;

  // one heap entry
  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] payload;
  } entry_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_MV,
    S_WR_X,
    S_RESULT
  } state_e;

endpackage

@@ rtl/binary_max_heap_queue.sv @@
// binary max-heap priority queue: sequencer, heap memory and result registers
// depends on bmhq_pkg and binary_max_heap_queue_macros.svh
//
// A command is taken when start is high and busy is low; busy stays high until
// the result has been shown. Each command gives one result on the result ports
// for a single cycle, marked by done_o, and it cannot be held off. The heap
// lives in a memory with one write and one registered read port, and that read
// port sets the latency. An insert reads the parent of the hole, compares it,
// and moves a smaller parent down into the hole, level by level, until the
// entry stops or reaches the root; then the entry is written. A remove reads
// the root and the last entry, then at each node reads the left and, if there
// is one, the right child and moves the larger child up while it beats the
// last entry, which is then written into the hole. A full insert or a remove
// on an empty heap goes straight to the result. After each result the block
// returns to idle to take the next command. No clearing pass runs after reset;
// the capacity register can be written whenever the block is idle.
module binary_max_heap_queue #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode_i,
  input  logic signed [31:0]        item_priority_i,
  input  logic signed [31:0]        item_payload_i,
  // result channel
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic signed [31:0]        out_priority_o,
  output logic signed [31:0]        out_payload_o,
  output logic [6:0]                entry_total_o,
  // capacity configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bmhq_pkg::CAP_W-1:0] capacity_limit_i
);
  import bmhq_pkg::*;
  `include "binary_max_heap_queue_macros.svh"

  localparam int unsigned ADDR_W = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IX_W   = ADDR_W + 2;
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(HEAP_DEPTH);

  // heap memory
  entry_t mem [HEAP_DEPTH];
  entry_t rd_data_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t            wr_data;

  // control and working registers
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [CAP_W-1:0]  cap_q;
  logic [ADDR_W-1:0] pos_q;
  logic [ADDR_W-1:0] best_idx_q;
  logic              take_q;
  entry_t            hold_q;
  entry_t            best_q;
  logic [1:0]        status_q;
  entry_t            out_q;

  // derived indexes and compares
  logic [ADDR_W-1:0] par, gpar;
  logic [IX_W-1:0]   cnt_ext, l_pos, r_pos, l_best;
  logic              r_ok, lb_ok, room, up_move;
  logic [CMP_W-1:0]  cap_ext, cap_eff;

  assign par     = (pos_q - ADDR_W'(1)) >> 1;
  assign gpar    = (par - ADDR_W'(1)) >> 1;
  assign cnt_ext = IX_W'(count_q);
  assign l_pos   = {1'b0, pos_q, 1'b1};
  assign r_pos   = l_pos + IX_W'(1);
  assign l_best  = {1'b0, best_idx_q, 1'b1};
  assign r_ok    = r_pos < cnt_ext;
  assign lb_ok   = l_best < cnt_ext;
  assign cap_ext = CMP_W'(cap_q);
  assign cap_eff = (cap_ext < DEPTH_C) ? cap_ext : DEPTH_C;
  assign room    = CMP_W'(count_q) < cap_eff;
  assign up_move = $signed(rd_data_q.prio) < $signed(hold_q.prio);

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and memory control
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = hold_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (opcode_i == OP_INSERT) begin
            state_d = room ? S_UP_RD : S_RESULT;
          end else if (count_q == '0) begin
            state_d = S_RESULT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = S_DN_ROOT;
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          state_d = S_WR_X;
        end else begin
          rd_en   = 1'b1;
          rd_addr = par;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (up_move) begin
          // parent moves down into the hole
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = rd_data_q;
          if (par == '0) begin
            state_d = S_WR_X;
          end else begin
            rd_en   = 1'b1;
            rd_addr = gpar;
            state_d = S_UP_CMP;
          end
        end else begin
          state_d = S_WR_X;
        end
      end
      S_DN_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(count_q - CNT_W'(1));
        state_d = S_DN_LAST;
      end
      S_DN_LAST: begin
        if (count_q > CNT_W'(1)) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(1);
          state_d = S_DN_L;
        end else begin
          state_d = S_WR_X;
        end
      end
      S_DN_L: begin
        if (r_ok) begin
          rd_en   = 1'b1;
          rd_addr = r_pos[ADDR_W-1:0];
          state_d = S_DN_R;
        end else begin
          state_d = S_DN_MV;
        end
      end
      S_DN_R: begin
        state_d = S_DN_MV;
      end
      S_DN_MV: begin
        if (take_q) begin
          // larger child moves up into the hole
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = best_q;
          if (lb_ok) begin
            rd_en   = 1'b1;
            rd_addr = l_best[ADDR_W-1:0];
            state_d = S_DN_L;
          end else begin
            state_d = S_WR_X;
          end
        end else begin
          state_d = S_WR_X;
        end
      end
      S_WR_X: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = hold_q;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // entry count and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= capacity_limit_i;
      end
      if (state_q == S_IDLE && start && opcode_i == OP_INSERT && room) begin
        count_q <= count_q + CNT_W'(1);
      end else if (state_q == S_DN_ROOT) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start) begin
          out_q            <= '0;
          hold_q.prio      <= item_priority_i;
          hold_q.payload   <= item_payload_i;
          pos_q            <= count_q[ADDR_W-1:0];
          if (opcode_i == OP_INSERT) begin
            status_q <= room ? ST_INSERTED : ST_FULL;
          end else begin
            status_q <= (count_q == '0) ? ST_EMPTY : ST_REMOVED;
          end
        end
      end
      S_UP_CMP: begin
        if (up_move) begin
          pos_q <= par;
        end
      end
      S_DN_ROOT: begin
        out_q <= rd_data_q;
      end
      S_DN_LAST: begin
        hold_q <= rd_data_q;
        pos_q  <= '0;
      end
      S_DN_L: begin
        // left child wins only when strictly larger
        if ($signed(hold_q.prio) < $signed(rd_data_q.prio)) begin
          best_q     <= rd_data_q;
          best_idx_q <= l_pos[ADDR_W-1:0];
          take_q     <= 1'b1;
        end else begin
          best_q <= hold_q;
          take_q <= 1'b0;
        end
      end
      S_DN_R: begin
        if ($signed(best_q.prio) < $signed(rd_data_q.prio)) begin
          best_q     <= rd_data_q;
          best_idx_q <= r_pos[ADDR_W-1:0];
          take_q     <= 1'b1;
        end
      end
      S_DN_MV: begin
        if (take_q) begin
          pos_q <= best_idx_q;
        end
      end
      default: begin
      end
    endcase
  end

  // ports
  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign done_o         = (state_q == S_RESULT);
  assign status_o       = status_q;
  assign out_priority_o = out_q.prio;
  assign out_payload_o  = out_q.payload;
  assign entry_total_o  = TOTAL_W'(count_q);

  // checks
  `BMHQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not set busy")
  `BMHQ_ASSERT_NEXT(a_done_pulse, done_o, !done_o && !busy, "result strobe longer than one cycle")
  `BMHQ_ASSERT(a_count_bound, count_q <= CNT_W'(HEAP_DEPTH), "entry count above heap depth")
  `BMHQ_ASSERT(a_zero_fields, done_o && status_o != ST_REMOVED |-> out_q == '0, "fields not zero")

endmodule
